### rtl/core/pal_pkg.sv
// Shared types and constants for the positional array list core.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package pal_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int POS_W        = 8;
    localparam int DATA_W       = 32;
    localparam int FUNC_W       = 2;
    localparam int STAT_W       = 2;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 56;

    typedef enum logic [FUNC_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOCATE = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_BADPOS   = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    // Command broadcast to every cell for one accepted transfer.
    typedef struct packed {
        logic              ins_en;
        logic              del_en;
        logic              loc_en;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } cmd_t;

    // Leaf of the search tree produced by each cell.
    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] data;
    } leaf_t;

endpackage

`default_nettype wire

### rtl/core/positional_array_list_core.sv
// Positional array list: bounded ordered list of signed 32-bit words.
// Input transfer (s_*): tuser = func (0 insert, 1 delete, 2 locate),
//   tdata = position and value. One result transfer (m_*) per input.
// Entries live in a row of CAPACITY cells; insert and delete shift the
// cells from the position onward toward a neighbor in the accept cycle.
// Locate and the read-out of a removed entry go through a registered
// priority tree of clog2(CAPACITY) levels; once the tree root holds the
// result, it is loaded into the output register and shown on m_tvalid.
// One item is in flight at a time; s_tready is high while the core idles.
// The result sits in an output register, so the next input is taken even
// while m_tready is low. If that earlier result still waits when the tree
// root is ready, park the new result in a hold register until it drains.
// Bad positions and inserts into a full list leave the list unchanged and
// report a status. Reset (aresetn low, synchronous) empties the list and
// drops any pending result; cell contents are not cleared since a cell is
// only read below the current length.
// Depends on pal_pkg, pal_cell, pal_reduce.
`default_nettype none

module positional_array_list_core #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [7:0] position, [39:8] value
    input  wire logic [pal_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] func
    input  wire logic [pal_pkg::FUNC_W-1:0]      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [1:0] status, [33:2] item, [41:34] found_at, [49:42] count, rest zero
    output logic [pal_pkg::M_TDATA_W-1:0]        m_tdata
);
    import pal_pkg::*;

    localparam int LEN_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int LEVELS = IDX_W;
    localparam int CNT_W  = $clog2(LEVELS + 1);
    localparam int CMP_W  = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;
    localparam int PAD_W  = M_TDATA_W - (STAT_W + DATA_W + 2 * POS_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUSY,
        S_WAIT
    } state_t;

    // ---- input unpack ----
    logic [POS_W-1:0]  in_pos;
    logic [DATA_W-1:0] in_value;
    logic              in_xfer;

    assign in_pos   = s_tdata[POS_W-1:0];
    assign in_value = s_tdata[POS_W+DATA_W-1:POS_W];
    assign in_xfer  = s_tvalid && s_tready;

    // ---- control registers ----
    state_t            state_reg,  state_next;
    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic              loc_reg,    loc_next;
    logic              del_reg,    del_next;
    status_t           stat_reg,   stat_next;
    logic [POS_W-1:0]  count_reg,  count_next;
    logic [DATA_W-1:0] hold_item_reg,  hold_item_next;
    logic [POS_W-1:0]  hold_found_reg, hold_found_next;
    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] out_stat_reg,  out_stat_next;
    logic [DATA_W-1:0] out_item_reg,  out_item_next;
    logic [POS_W-1:0]  out_found_reg, out_found_next;
    logic [POS_W-1:0]  out_count_reg, out_count_next;

    // ---- position checks ----
    logic [CMP_W-1:0] pos_c, len_c;
    logic             ins_pos_ok, del_pos_ok, list_full;
    logic             ins_ok, del_ok;
    cmd_t             cmd;

    assign pos_c      = CMP_W'(in_pos);
    assign len_c      = CMP_W'(length_reg);
    assign ins_pos_ok = (pos_c != '0) && (pos_c <= len_c + CMP_W'(1));
    assign del_pos_ok = (pos_c != '0) && (pos_c <= len_c);
    assign list_full  = (len_c >= CMP_W'(CAPACITY));
    assign ins_ok     = in_xfer && (s_tuser == OP_INSERT) && ins_pos_ok && !list_full;
    assign del_ok     = in_xfer && (s_tuser == OP_DELETE) && del_pos_ok;

    assign cmd.ins_en = ins_ok;
    assign cmd.del_en = del_ok;
    assign cmd.loc_en = in_xfer && (s_tuser == OP_LOCATE);
    assign cmd.pos    = in_pos;
    assign cmd.value  = in_value;

    // ---- row of cells ----
    logic [DATA_W-1:0] cell_val [CAPACITY];
    leaf_t             leaves   [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] left_val, right_val;
        if (i == 0) begin : g_first
            assign left_val = cell_val[i];
        end else begin : g_left
            assign left_val = cell_val[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_val = cell_val[i];
        end else begin : g_right
            assign right_val = cell_val[i+1];
        end
        pal_cell #(
            .INDEX    (i),
            .CAPACITY (CAPACITY)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .length    (length_reg),
            .left_val  (left_val),
            .right_val (right_val),
            .cell_val  (cell_val[i]),
            .leaf      (leaves[i])
        );
    end

    // ---- search tree ----
    logic              root_hit;
    logic [IDX_W-1:0]  root_idx;
    logic [DATA_W-1:0] root_data;
    logic [IDX_W:0]    found_wide;

    pal_reduce #(
        .CAPACITY (CAPACITY)
    ) u_reduce (
        .aclk      (aclk),
        .leaves    (leaves),
        .root_hit  (root_hit),
        .root_idx  (root_idx),
        .root_data (root_data)
    );

    assign found_wide = {1'b0, root_idx} + (IDX_W + 1)'(1);

    // ---- result fields from the tree root ----
    status_t           res_stat;
    logic [DATA_W-1:0] res_item;
    logic [POS_W-1:0]  res_found;

    always_comb begin
        res_stat  = stat_reg;
        res_item  = '0;
        res_found = '0;
        if (loc_reg) begin
            if (root_hit) begin
                res_item  = root_data;
                res_found = POS_W'(found_wide);
            end else begin
                res_stat = STAT_NOTFOUND;
            end
        end else if (del_reg) begin
            res_item = root_data;
        end
    end

    // ---- sequencer ----
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        length_next     = length_reg;
        loc_next        = loc_reg;
        del_next        = del_reg;
        stat_next       = stat_reg;
        count_next      = count_reg;
        hold_item_next  = hold_item_reg;
        hold_found_next = hold_found_reg;
        out_valid_next  = out_valid_reg;
        out_stat_next   = out_stat_reg;
        out_item_next   = out_item_reg;
        out_found_next  = out_found_reg;
        out_count_next  = out_count_reg;

        // drop the result once the receiver takes it
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    if (ins_ok) begin
                        length_next = length_reg + LEN_W'(1);
                    end else if (del_ok) begin
                        length_next = length_reg - LEN_W'(1);
                    end
                    loc_next = cmd.loc_en;
                    del_next = del_ok;
                    unique case (s_tuser)
                        OP_INSERT: stat_next = !ins_pos_ok ? STAT_BADPOS :
                                               (list_full ? STAT_FULL : STAT_OK);
                        OP_DELETE: stat_next = del_pos_ok ? STAT_OK : STAT_BADPOS;
                        default:   stat_next = STAT_OK;
                    endcase
                    count_next = POS_W'(length_next);
                    cnt_next   = CNT_W'(LEVELS);
                    state_next = S_BUSY;
                end
            end
            S_BUSY: begin
                if (cnt_reg != '0) begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end else if (!out_valid_reg || m_tready) begin
                    // tree root holds this item's search result: load the output
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    out_found_next = res_found;
                    out_item_next  = res_item;
                    out_stat_next  = res_stat;
                    state_next     = S_IDLE;
                end else begin
                    // root moves on next cycle: park the result while the output stalls
                    stat_next       = res_stat;
                    hold_item_next  = res_item;
                    hold_found_next = res_found;
                    state_next      = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    out_found_next = hold_found_reg;
                    out_item_next  = hold_item_reg;
                    out_stat_next  = stat_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            length_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            length_reg    <= length_next;
            out_valid_reg <= out_valid_next;
        end
        loc_reg        <= loc_next;
        del_reg        <= del_next;
        stat_reg       <= stat_next;
        count_reg      <= count_next;
        hold_item_reg  <= hold_item_next;
        hold_found_reg <= hold_found_next;
        out_stat_reg   <= out_stat_next;
        out_item_reg   <= out_item_next;
        out_found_reg  <= out_found_next;
        out_count_reg  <= out_count_next;
    end

    // ---- ports ----
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_count_reg, out_found_reg,
                       out_item_reg, out_stat_reg};

endmodule

`default_nettype wire

### rtl/core/pal_cell.sv
// One storage cell of the list: holds one entry and shifts with its neighbors.
// Depends on pal_pkg (cmd_t, leaf_t, widths).
`default_nettype none

module pal_cell #(
    parameter int INDEX    = 0,
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
    input  wire logic                             aclk,
    input  wire pal_pkg::cmd_t                    cmd,
    input  wire logic [$clog2(CAPACITY+1)-1:0]    length,
    input  wire logic [pal_pkg::DATA_W-1:0]       left_val,
    input  wire logic [pal_pkg::DATA_W-1:0]       right_val,
    output logic      [pal_pkg::DATA_W-1:0]       cell_val,
    output pal_pkg::leaf_t                        leaf
);
    import pal_pkg::*;

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;
    localparam logic [CMP_W-1:0] IDX_C  = CMP_W'(INDEX);
    localparam logic [CMP_W-1:0] IDX_P1 = CMP_W'(INDEX + 1);

    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;
    logic [CMP_W-1:0]  pos_c;
    logic [CMP_W-1:0]  len_c;

    assign pos_c = CMP_W'(cmd.pos);
    assign len_c = CMP_W'(length);

    always_comb begin
        val_next = val_reg;
        if (cmd.ins_en) begin
            if (IDX_C >= pos_c) begin
                val_next = left_val;
            end else if (IDX_P1 == pos_c) begin
                val_next = cmd.value;
            end
        end else if (cmd.del_en) begin
            if (IDX_P1 >= pos_c) begin
                val_next = right_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign cell_val  = val_reg;
    // flag this cell for the search: an equal entry below the length, or the entry to remove
    assign leaf.hit  = (cmd.loc_en && (IDX_C < len_c) && (val_reg == cmd.value)) ||
                       (cmd.del_en && (IDX_P1 == pos_c));
    assign leaf.data = val_reg;

endmodule

`default_nettype wire

### rtl/core/pal_reduce.sv
// Registered priority tree: finds the lowest flagged cell and its entry.
// Depends on pal_pkg (leaf_t, widths). Leaves and every tree node are registered.
`default_nettype none

module pal_reduce #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
    input  wire logic                           aclk,
    input  wire pal_pkg::leaf_t                 leaves [CAPACITY],
    output logic                                root_hit,
    output logic [$clog2(CAPACITY)-1:0]         root_idx,
    output logic [pal_pkg::DATA_W-1:0]          root_data
);
    import pal_pkg::*;

    localparam int LEVELS = $clog2(CAPACITY);
    localparam int IDX_W  = LEVELS;
    localparam int N      = 1 << LEVELS;

    logic              hit_reg  [1:2*N-1];
    logic [IDX_W-1:0]  idx_reg  [1:2*N-1];
    logic [DATA_W-1:0] data_reg [1:2*N-1];

    for (genvar j = 0; j < N; j++) begin : g_leaf
        if (j < CAPACITY) begin : g_used
            always_ff @(posedge aclk) begin
                hit_reg[N+j]  <= leaves[j].hit;
                idx_reg[N+j]  <= IDX_W'(j);
                data_reg[N+j] <= leaves[j].data;
            end
        end else begin : g_pad
            always_ff @(posedge aclk) begin
                hit_reg[N+j]  <= 1'b0;
                idx_reg[N+j]  <= IDX_W'(j);
                data_reg[N+j] <= '0;
            end
        end
    end

    // lower index wins
    for (genvar k = 1; k < N; k++) begin : g_node
        always_ff @(posedge aclk) begin
            if (hit_reg[2*k]) begin
                hit_reg[k]  <= 1'b1;
                idx_reg[k]  <= idx_reg[2*k];
                data_reg[k] <= data_reg[2*k];
            end else begin
                hit_reg[k]  <= hit_reg[2*k+1];
                idx_reg[k]  <= idx_reg[2*k+1];
                data_reg[k] <= data_reg[2*k+1];
            end
        end
    end

    assign root_hit  = hit_reg[1];
    assign root_idx  = idx_reg[1];
    assign root_data = data_reg[1];

endmodule

`default_nettype wire

### rtl/core/pal_checker.sv
// Port-level checks for positional_array_list_core, attached by bind.
// Depends on pal_pkg (status codes, widths).
`default_nettype none

module pal_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [pal_pkg::M_TDATA_W-1:0]   m_tdata
);
    import pal_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // one item in flight: no input taken in the cycle after a transfer
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in flight");

    // reset drops any pending result
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a failed operation carries no item and no position
    a_fail_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[STAT_W-1:0] != STAT_OK) |->
            (m_tdata[STAT_W+DATA_W-1:STAT_W] == '0) &&
            (m_tdata[STAT_W+DATA_W+POS_W-1:STAT_W+DATA_W] == '0))
        else $error("failed operation returned data");

endmodule

bind positional_array_list_core pal_checker u_pal_checker (.*);

`default_nettype wire

### tb/positional_array_list_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for positional_array_list_core: drives insert, delete and locate
// transfers, keeps a behavioral copy of the list and checks every result transfer.
// Depends on pal_pkg and the positional_array_list_core RTL.

module positional_array_list_core_test;
    import pal_pkg::*;

    localparam int CAPACITY = CAPACITY_DEF;
    // func code that the core has no operation for; it must report ok and change nothing
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    // cycles without any transfer before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // leave generous slack after the last result for any stray result
    localparam int DRAIN_CYCLES = 24;

    // Result fields, most significant first, so the struct lines up with m_tdata[49:0]
    typedef struct packed {
        logic [POS_W-1:0]  count;
        logic [POS_W-1:0]  found_at;
        logic [DATA_W-1:0] item;
        status_t           status;
    } list_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;    // [7:0] position, [39:8] value
    logic [FUNC_W-1:0]    s_tuser  = '0;    // [1:0] func
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [1:0] status, [33:2] item, [41:34] found_at,
                                            // [49:42] count

    // Behavioral copy of the list; entries at or above list_len are never read
    logic [DATA_W-1:0] list_words [CAPACITY];
    int unsigned       list_len = 0;

    // Results owed by the core, oldest first
    list_result_t      pending_results [$];

    // Idling knobs, in percent of cycles
    int unsigned       send_idle_pct  = 0;
    int unsigned       recv_stall_pct = 0;

    bit                mismatch_seen = 1'b0;
    int                quiet_cycles  = 0;

    positional_array_list_core #(
        .CAPACITY (CAPACITY)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one operation to the list copy and return the result it must produce.
    // Position is checked before fullness, so a bad position on a full list is a bad position.
    function automatic list_result_t apply_list_op(input logic [FUNC_W-1:0] func,
                                                   input logic [POS_W-1:0]  pos,
                                                   input logic [DATA_W-1:0] value);
        list_result_t r;
        int unsigned  k;
        r.status   = STAT_OK;
        r.item     = '0;
        r.found_at = '0;
        case (func)
            OP_INSERT: begin
                if (pos == 0 || pos > list_len + 1) begin
                    r.status = STAT_BADPOS;
                end else if (list_len >= CAPACITY) begin
                    r.status = STAT_FULL;
                end else begin
                    // open a gap at pos by moving the tail up one slot
                    for (k = list_len; k > pos - 1; k--)
                        list_words[k] = list_words[k - 1];
                    list_words[pos - 1] = value;
                    list_len++;
                end
            end
            OP_DELETE: begin
                if (pos == 0 || pos > list_len) begin
                    r.status = STAT_BADPOS;
                end else begin
                    r.item = list_words[pos - 1];
                    for (k = pos - 1; k + 1 < list_len; k++)
                        list_words[k] = list_words[k + 1];
                    list_len--;
                end
            end
            OP_LOCATE: begin
                // first match wins; stop scanning once one is found
                r.status = STAT_NOTFOUND;
                for (k = 0; k < list_len && r.status != STAT_OK; k++) begin
                    if (list_words[k] == value) begin
                        r.status   = STAT_OK;
                        r.item     = value;
                        r.found_at = POS_W'(k + 1);
                    end
                end
            end
            default: begin
                // unused code: nothing moves, plain ok
            end
        endcase
        r.count = POS_W'(list_len);
        return r;
    endfunction

    // Offer one input transfer. Idle first at the current sender rate, then hold tvalid
    // until the core takes it. Acceptance is decided at the negedge before the capturing
    // edge, where tvalid and tready are settled, so the expectation is queued race-free.
    task automatic send_list_op(input logic [FUNC_W-1:0] func,
                                input logic [POS_W-1:0]  pos,
                                input logic [DATA_W-1:0] value);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {value, pos};
        do begin
            @(negedge aclk);
            taken = s_tready;
            if (taken)
                pending_results.push_back(apply_list_op(func, pos, value));
            @(posedge aclk);
        end while (!taken);
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Values lean on the extremes and a dense small pool so that duplicates show up
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4, 5:    return DATA_W'($urandom_range(15));
            default: return $urandom;
        endcase
    endfunction

    // Empty-list corner cases, signed extremes, duplicates, every status but full and the unused code
    task automatic test_directed();
        set_idling(0, 0);
        send_list_op(OP_DELETE, 8'd1, 32'h0);             // delete from empty list
        send_list_op(OP_DELETE, 8'd0, 32'h0);             // position zero
        send_list_op(OP_LOCATE, 8'd0, 32'h0);             // locate on empty list
        send_list_op(OP_INSERT, 8'd0, 32'h5);             // insert at position zero
        send_list_op(OP_INSERT, 8'd2, 32'h5);             // insert past end + 1
        send_list_op(OP_INSERT, 8'd1, 32'h8000_0000);     // most negative value
        send_list_op(OP_INSERT, 8'd2, 32'h7FFF_FFFF);     // append most positive value
        send_list_op(OP_INSERT, 8'd1, 32'h0000_0000);     // insert at head
        send_list_op(OP_INSERT, 8'd2, 32'hFFFF_FFFF);     // insert in the middle
        send_list_op(OP_INSERT, 8'd5, 32'h7FFF_FFFF);     // duplicate at the tail
        send_list_op(OP_INSERT, 8'hFF, 32'h1);            // largest position field
        send_list_op(OP_LOCATE, 8'd0, 32'h7FFF_FFFF);     // first of two equal entries
        send_list_op(OP_LOCATE, 8'hFF, 32'h8000_0000);    // position field ignored
        send_list_op(OP_LOCATE, 8'd0, 32'h0000_3039);     // miss
        send_list_op(FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF);  // unused code
        send_list_op(OP_DELETE, 8'd6, 32'h0);             // one past the length
        send_list_op(OP_DELETE, 8'hFF, 32'h0);
        send_list_op(OP_DELETE, 8'd3, 32'h0);             // middle
        send_list_op(OP_DELETE, 8'd4, 32'h0);             // tail
        send_list_op(OP_DELETE, 8'd1, 32'h0);             // head
        send_list_op(OP_LOCATE, 8'd0, 32'h7FFF_FFFF);
        send_list_op(FUNC_UNUSED, 8'd0, 32'h0);
        send_list_op(OP_INSERT, 8'd3, 32'hAAAA_AAAA);     // append at length + 1
        send_list_op(OP_DELETE, 8'd0, 32'h5555_5555);
    endtask

    // Mostly well-formed traffic with random content; the rest is bad positions and noise.
    // Insert and delete odds swap around half capacity so the length keeps wandering.
    task automatic run_random_ops(input int n);
        int unsigned r;
        int unsigned grow;
        logic [DATA_W-1:0] probe;
        repeat (n) begin
            r    = $urandom_range(99);
            grow = (list_len < CAPACITY / 2) ? 45 : 25;
            if (r < grow) begin
                send_list_op(OP_INSERT, POS_W'($urandom_range(list_len + 1, 1)), pick_value());
            end else if (r < 70) begin
                send_list_op(OP_DELETE, POS_W'($urandom_range(list_len > 0 ? list_len : 1, 1)),
                             pick_value());
            end else if (r < 85) begin
                probe = pick_value();
                if (list_len > 0 && $urandom_range(2) != 0)
                    probe = list_words[$urandom_range(list_len - 1)];
                send_list_op(OP_LOCATE, POS_W'($urandom), probe);
            end else if (r < 94) begin
                // any position field at all, mostly out of range
                send_list_op($urandom_range(1) ? OP_INSERT : OP_DELETE, POS_W'($urandom),
                             pick_value());
            end else begin
                send_list_op(FUNC_UNUSED, POS_W'($urandom), $urandom);
            end
        end
    endtask

    // Sweep the idling patterns so gaps hit every part of the core's cycle
    task automatic test_random_traffic();
        set_idling(0, 0);
        run_random_ops(60);
        set_idling(88, 0);
        run_random_ops(60);
        set_idling(0, 88);
        run_random_ops(60);
        set_idling(33, 33);
        run_random_ops(60);
    endtask

    // Grow the list to capacity, then probe the full-list and boundary cases
    task automatic test_fill_to_capacity();
        logic [DATA_W-1:0] last_value;
        set_idling(33, 33);
        last_value = '0;
        while (list_len < CAPACITY) begin
            last_value = pick_value();
            send_list_op(OP_INSERT, POS_W'($urandom_range(list_len + 1, 1)), last_value);
        end
        send_list_op(OP_INSERT, POS_W'(CAPACITY + 1), 32'h1234_5678);  // good position, full
        send_list_op(OP_INSERT, 8'd1, 32'h0000_0001);                  // full
        send_list_op(OP_INSERT, POS_W'(CAPACITY + 2), 32'h1);          // position wins over full
        send_list_op(OP_INSERT, 8'd0, 32'h1);
        send_list_op(OP_LOCATE, 8'd0, last_value);
        send_list_op(OP_LOCATE, 8'd0, list_words[CAPACITY - 1]);
        send_list_op(OP_DELETE, POS_W'(CAPACITY), 32'h0);              // last slot
        send_list_op(OP_DELETE, POS_W'(CAPACITY), 32'h0);              // now past the end
        send_list_op(OP_INSERT, POS_W'(CAPACITY - 1), 32'hDEAD_BEEF);
        send_list_op(OP_INSERT, 8'd64, 32'h8000_0000);                 // still full
        send_list_op(FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF);
        send_list_op(OP_DELETE, 8'd1, 32'h0);
    endtask

    // Receiver: drop tready at the current stall rate
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    function automatic void report_field(input string name, input logic [DATA_W-1:0] want,
                                         input logic [DATA_W-1:0] got);
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        mismatch_seen = 1'b1;
    endfunction

    // Result checker: sampled at the negedge ahead of the capturing edge, where the
    // handshake is settled. Compare each field against the oldest expectation.
    always @(negedge aclk) begin
        list_result_t want;
        list_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = list_result_t'(m_tdata[49:0]);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
                mismatch_seen = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report_field("status", DATA_W'(want.status), DATA_W'(got.status));
                if (got.item !== want.item)
                    report_field("item", want.item, got.item);
                if (got.found_at !== want.found_at)
                    report_field("found_at", DATA_W'(want.found_at), DATA_W'(got.found_at));
                if (got.count !== want.count)
                    report_field("count", DATA_W'(want.count), DATA_W'(got.count));
            end
        end
    end

    // Watchdog: any transfer on either side restarts the count
    always @(negedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_traffic();
        test_fill_to_capacity();

        // release the input, collect what is still in flight, then hold for stray results
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (!mismatch_seen)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
